/* hdl/swm_pkg.sv */
// swm_pkg: shared constants for the sliding window maximum block
// no dependencies; imported by the cell and the top level
`default_nettype none
package swm_pkg;
   localparam int unsigned CSR_WIDTH    = 7;
   localparam int unsigned WINDOW_RESET = 1;

   typedef logic [CSR_WIDTH-1:0] csr_word_type;
endpackage
`default_nettype wire

/* hdl/swm_cell.sv */
// swm_cell: one cell of the running-maximum chain
// holds the maximum of the last (position + 1) samples; depends on swm_pkg
`default_nettype none
module swm_cell
   import swm_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    load,
   input  wire logic signed [WIDTH-1:0] sample_in,
   input  wire logic signed [WIDTH-1:0] prev_in,
   output logic signed [WIDTH-1:0]      max_out
);
   logic signed [WIDTH-1:0] max_ff;
   logic signed [WIDTH-1:0] max_in;

   always_comb begin
      max_in = (prev_in > sample_in) ? prev_in : sample_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         max_ff <= max_in;
      end
   end

   assign max_out = max_ff;
endmodule
`default_nettype wire

/* hdl/sliding_window_maximum.sv */
// sliding_window_maximum: top level, a chain of running-max cells
// the result word is registered when its sample word is taken
// throughput: one sample word per cycle while req_stall is low, set by one compare per cell
// reset: window size 1, fill count and result valid cleared; cells unreset
// a window size write or frame_start restarts the window fill
// depends on swm_pkg and swm_cell
`default_nettype none
module sliding_window_maximum
   import swm_pkg::*;
#(
   parameter int unsigned MAX_WINDOW   = 64,
   parameter int unsigned SAMPLE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                           req_frame_start,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_window_max,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [CSR_WIDTH-1:0]           csr_window_size
);
   localparam int unsigned COUNT_W = $clog2(MAX_WINDOW + 1);
   localparam int unsigned IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   csr_word_type                   window_ff;
   logic [COUNT_W-1:0]             seen_ff, seen_in;
   logic [COUNT_W-1:0]             win, win_m1, base;
   logic [IDX_W-1:0]               tap_idx;
   logic                           accept, has_result;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_max_ff, rsp_max_in, tap;
   logic signed [SAMPLE_WIDTH-1:0] prev_vec [MAX_WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] cell_max [MAX_WINDOW];

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // effective window size, clamped to 1..MAX_WINDOW
   always_comb begin
      if (window_ff == '0) begin
         win = COUNT_W'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         win = COUNT_W'(MAX_WINDOW);
      end else begin
         win = COUNT_W'(window_ff);
      end
      win_m1  = win - COUNT_W'(1);
      tap_idx = win_m1[IDX_W-1:0];
   end

   // cell chain
   assign prev_vec[0] = req_sample;
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign prev_vec[k] = cell_max[k-1];
      end
      swm_cell #(
         .WIDTH(SAMPLE_WIDTH)
      ) u_cell (
         .clock    (clock),
         .load     (accept),
         .sample_in(req_sample),
         .prev_in  (prev_vec[k]),
         .max_out  (cell_max[k])
      );
   end

   always_comb begin
      tap        = prev_vec[tap_idx];
      rsp_max_in = (tap > req_sample) ? tap : req_sample;
      base       = req_frame_start ? '0 : seen_ff;
      seen_in    = (base < win) ? base + COUNT_W'(1) : base;
      has_result = (seen_in >= win);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= CSR_WIDTH'(WINDOW_RESET);
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_ff <= csr_window_size;
            seen_ff   <= '0;
         end else if (accept) begin
            seen_ff <= seen_in;
         end
         if (accept) begin
            rsp_valid_ff <= has_result;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         rsp_max_ff <= rsp_max_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;
endmodule
`default_nettype wire

/* tb/tb.sv */
// tb: self-checking testbench for sliding_window_maximum, driven from its ports
// keeps its own monotonic-deque predictor of the window maximum; depends on swm_pkg
`timescale 1ns / 1ps
module tb
   import swm_pkg::*;
();

   localparam int SW    = 32;
   localparam int WMAX  = 64;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [SW-1:0] req_sample = '0;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [SW-1:0] rsp_window_max;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_word_type         csr_window_size = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int errors         = 0;

   // predictor state
   int                   win_eff = WINDOW_RESET;
   int                   frame_fill = 0;
   logic signed [SW-1:0] cand_q[$];
   logic signed [SW-1:0] frame_hist_q[$];
   logic signed [SW-1:0] max_expected_q[$];

   sliding_window_maximum dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_max  (rsp_window_max),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (max_expected_q.size() == 0) begin
            $display("%0t unexpected window_max word %0d", $time, rsp_window_max);
            errors++;
         end else begin
            if (rsp_window_max !== max_expected_q[0]) begin
               $display("%0t window_max expected %0d actual %0d",
                        $time, max_expected_q[0], rsp_window_max);
               errors++;
            end
            max_expected_q.delete(0);
         end
      end
   end

   function automatic void clear_frame();
      cand_q.delete();
      frame_hist_q.delete();
      frame_fill = 0;
   endfunction

   function automatic void predict_window_max(input logic signed [SW-1:0] s,
                                              input logic fs);
      logic signed [SW-1:0] leaving;
      if (fs)
         clear_frame();
      if (frame_fill >= win_eff) begin
         leaving = frame_hist_q[0];
         frame_hist_q.delete(0);
         if (cand_q.size() > 0 && cand_q[0] == leaving)
            cand_q.delete(0);
      end
      while (cand_q.size() > 0 && cand_q[cand_q.size()-1] < s)
         cand_q.delete(cand_q.size()-1);
      cand_q.insert(cand_q.size(), s);
      frame_hist_q.insert(frame_hist_q.size(), s);
      if (frame_fill < win_eff)
         frame_fill++;
      if (frame_fill >= win_eff)
         max_expected_q.insert(max_expected_q.size(), cand_q[0]);
   endfunction

   function automatic logic signed [SW-1:0] pick_sample();
      logic signed [SW-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $signed($urandom_range(0, 7)) - 4;
         4: v = $urandom_range(0, 1) ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_sample(input logic signed [SW-1:0] s, input logic fs);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      predict_window_max(s, fs);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (max_expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input csr_word_type v);
      wait_quiet();
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_window_size <= v;
      do @(posedge clock); while (!csr_ready);
      if (v == 0)
         win_eff = 1;
      else if (v > WMAX)
         win_eff = WMAX;
      else
         win_eff = int'(v);
      clear_frame();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // window of one from reset, full-scale samples
   task automatic test_reset_window();
      send_sample(32'sh7fffffff, 1'b1);
      send_sample(32'sh80000000, 1'b0);
      send_sample(32'sh00000000, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd1, 1'b0);
   endtask

   // zero size, equal samples, short frame, size change mid-frame
   task automatic test_directed_cases();
      write_window(7'd0);
      send_sample(32'sd9, 1'b1);
      send_sample(-32'sd9, 1'b0);
      write_window(7'd3);
      send_sample(32'sd5, 1'b1);
      send_sample(32'sd5, 1'b0);
      send_sample(32'sd5, 1'b0);
      send_sample(32'sd2, 1'b0);
      send_sample(32'sd5, 1'b0);
      send_sample(32'sd1, 1'b0);
      send_sample(32'sd1, 1'b0);
      write_window(7'd4);
      send_sample(32'sd100, 1'b1);
      send_sample(32'sd50, 1'b0);
      send_sample(-32'sd3, 1'b1);
      send_sample(-32'sd7, 1'b0);
      send_sample(-32'sd3, 1'b0);
      send_sample(-32'sd8, 1'b0);
      send_sample(-32'sd9, 1'b0);
      write_window(7'd2);
      send_sample(32'sd4, 1'b0);
      send_sample(32'sd6, 1'b0);
      send_sample(32'sd3, 1'b0);
   endtask

   task automatic test_random_frames();
      csr_word_type edge_sizes[4];
      csr_word_type wsize;
      int           phase;
      int           k;
      int           sent;
      int           flen;
      int           w;
      int           i;
      edge_sizes = '{7'd127, 7'd0, 7'd64, 7'd1};
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         for (k = 0; k < 2; k++) begin
            if (k == 0)
               wsize = edge_sizes[phase];
            else if ($urandom_range(0, 5) == 0)
               wsize = csr_word_type'($urandom_range(0, 127));
            else
               wsize = csr_word_type'($urandom_range(1, 8));
            write_window(wsize);
            w = (wsize == 0) ? 1 : ((wsize > WMAX) ? WMAX : int'(wsize));
            sent = 0;
            while (sent < 90) begin
               if ($urandom_range(0, 9) == 0)
                  flen = $urandom_range(1, w);
               else
                  flen = w + $urandom_range(0, 3 * w + 10);
               for (i = 0; i < flen; i++)
                  send_sample(pick_sample(), (i == 0) || ($urandom_range(0, 99) == 0));
               sent += flen;
            end
         end
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_window();
      test_directed_cases();
      test_random_frames();
      wait_quiet();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

/* filelist.f */
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_maximum.sv
tb/tb.sv
